// File: design/fcbf_pkg.sv
// shared types and constants for the flow-controlled byte fifo
package fcbf_pkg;

	localparam int CAPACITY_DEF  = 1024;
	localparam int MAX_BURST_DEF = 64;

	localparam int CMD_W  = 3;
	localparam int BYTE_W = 8;
	localparam int CNT_W  = 11;
	localparam int TOT_W  = 32;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	localparam logic [CMD_W-1:0] CMD_WRITE = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PEEK  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_POP   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_READ  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_END   = 3'd4;

	typedef enum logic [2:0] {
		OP_WRITE,
		OP_PEEK,
		OP_POP,
		OP_READ,
		OP_END,
		OP_NOP
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [BYTE_W-1:0] data_byte;
		logic [CNT_W-1:0]  count;
	} fcbf_item_t;

	typedef enum logic {
		BK_IDLE,
		BK_BURST
	} back_state_t;

endpackage

// File: design/fcbf_front.sv
// front end: command decode, burst clamp and a two-entry command queue
module fcbf_front import fcbf_pkg::*; #(
	parameter int MAX_BURST = MAX_BURST_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [CMD_W-1:0]  cmd,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic [CNT_W-1:0]  count,
	output logic              q_valid,
	output fcbf_item_t        q_item,
	input  logic              q_take
);

	fcbf_item_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]       wr_ptr_q;
	logic [QPTR_W-1:0]       rd_ptr_q;
	logic [QCNT_W-1:0]       fill_q;
	fcbf_item_t              item;
	logic                    push;
	logic                    pop;

	always_comb begin
		item.data_byte = data_byte;
		item.count     = count;
		unique case (cmd)
			CMD_WRITE: item.op = OP_WRITE;
			CMD_PEEK:  item.op = OP_PEEK;
			CMD_POP:   item.op = OP_POP;
			CMD_READ:  item.op = OP_READ;
			CMD_END:   item.op = OP_END;
			default:   item.op = OP_NOP;
		endcase
		// peek and read never move more than one burst
		if ((item.op == OP_PEEK || item.op == OP_READ) && count > CNT_W'(MAX_BURST)) begin
			item.count = CNT_W'(MAX_BURST);
		end
	end

	assign in_stall = (fill_q == QCNT_W'(QUEUE_DEPTH));
	assign push     = in_valid && !in_stall;
	assign q_valid  = (fill_q != '0);
	assign q_item   = slot_q[rd_ptr_q];
	assign pop      = q_take && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= item;
		end
	end

endmodule

// File: design/fcbf_back.sv
// back end: ring store, pointers, totals, burst sequencer and result register
module fcbf_back import fcbf_pkg::*; #(
	parameter int CAPACITY  = CAPACITY_DEF,
	parameter int MAX_BURST = MAX_BURST_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  fcbf_item_t        q_item,
	output logic              q_take,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [BYTE_W-1:0] out_byte,
	output logic              byte_valid,
	output logic              last,
	output logic [CNT_W-1:0]  done_count,
	output logic [CNT_W-1:0]  fill_level,
	output logic [CNT_W-1:0]  space_left,
	output logic [TOT_W-1:0]  total_written,
	output logic [TOT_W-1:0]  total_read,
	output logic              ended,
	output logic              at_eof
);

	localparam int FW = $clog2(CAPACITY + 1);
	localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int SW = FW + 1;
	localparam int BW = $clog2(MAX_BURST + 1);
	localparam int MW = (FW > CNT_W) ? FW : CNT_W;

	logic [BYTE_W-1:0] mem [CAPACITY];

	back_state_t       state_q, state_nx;
	logic [PW-1:0]     head_q, head_nx;
	logic [FW-1:0]     fill_q, fill_nx;
	logic [TOT_W-1:0]  wtot_q, wtot_nx;
	logic [TOT_W-1:0]  rtot_q, rtot_nx;
	logic              ended_q, ended_nx;
	logic [PW-1:0]     rd_ptr_q;
	logic [BW-1:0]     issue_left_q;
	logic [BW-1:0]     emit_left_q;
	logic [CNT_W-1:0]  burst_done_q;
	logic [BYTE_W-1:0] rd_data_q;
	logic              rd_valid_q;

	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              byte_valid_q;
	logic              last_q;
	logic [CNT_W-1:0]  done_q;
	logic [CNT_W-1:0]  fill_level_q;
	logic [CNT_W-1:0]  space_left_q;
	logic [TOT_W-1:0]  total_written_q;
	logic [TOT_W-1:0]  total_read_q;
	logic              ended_out_q;
	logic              at_eof_q;

	logic              slot_free;
	logic [PW-1:0]     tail;
	logic [MW-1:0]     req_m;
	logic [FW-1:0]     n_fw;
	logic              mem_we;
	logic              burst_start;
	logic              issue;
	logic              consume;
	logic              out_load;
	logic [BYTE_W-1:0] ld_byte;
	logic              ld_bv;
	logic              ld_last;
	logic [CNT_W-1:0]  ld_done;

	function automatic logic [PW-1:0] wrap_add(logic [PW-1:0] a, logic [FW-1:0] b);
		logic [SW-1:0] s;
		s = SW'(a) + SW'(b);
		if (s >= SW'(CAPACITY)) begin
			s = s - SW'(CAPACITY);
		end
		return PW'(s);
	endfunction

	assign slot_free = !out_valid_q || !out_stall;
	assign q_take    = (state_q == BK_IDLE) && q_valid && slot_free;
	assign tail      = wrap_add(head_q, fill_q);
	assign req_m     = (MW'(q_item.count) < MW'(fill_q)) ? MW'(q_item.count) : MW'(fill_q);
	assign n_fw      = FW'(req_m);

	always_comb begin
		state_nx    = state_q;
		head_nx     = head_q;
		fill_nx     = fill_q;
		wtot_nx     = wtot_q;
		rtot_nx     = rtot_q;
		ended_nx    = ended_q;
		mem_we      = 1'b0;
		burst_start = 1'b0;
		issue       = 1'b0;
		consume     = 1'b0;
		out_load    = 1'b0;
		ld_byte     = '0;
		ld_bv       = 1'b0;
		ld_last     = 1'b1;
		ld_done     = '0;
		unique case (state_q)
			BK_IDLE: begin
				if (q_take) begin
					unique case (q_item.op)
						OP_WRITE: begin
							out_load = 1'b1;
							if (fill_q != FW'(CAPACITY)) begin
								mem_we  = 1'b1;
								fill_nx = fill_q + 1'b1;
								wtot_nx = wtot_q + 1'b1;
								ld_done = CNT_W'(1);
							end
						end
						OP_PEEK, OP_READ: begin
							if (n_fw == '0) begin
								out_load = 1'b1;
							end else begin
								burst_start = 1'b1;
								state_nx    = BK_BURST;
								if (q_item.op == OP_READ) begin
									head_nx = wrap_add(head_q, n_fw);
									fill_nx = fill_q - n_fw;
									rtot_nx = rtot_q + TOT_W'(n_fw);
								end
							end
						end
						OP_POP: begin
							out_load = 1'b1;
							head_nx  = wrap_add(head_q, n_fw);
							fill_nx  = fill_q - n_fw;
							rtot_nx  = rtot_q + TOT_W'(n_fw);
							ld_done  = CNT_W'(n_fw);
						end
						OP_END: begin
							out_load = 1'b1;
							ended_nx = 1'b1;
						end
						default: begin
							out_load = 1'b1;
						end
					endcase
				end
			end
			BK_BURST: begin
				consume = rd_valid_q && slot_free;
				issue   = (issue_left_q != '0) && (!rd_valid_q || consume);
				if (consume) begin
					out_load = 1'b1;
					ld_byte  = rd_data_q;
					ld_bv    = 1'b1;
					ld_last  = (emit_left_q == BW'(1));
					ld_done  = burst_done_q;
					if (emit_left_q == BW'(1)) begin
						state_nx = BK_IDLE;
					end
				end
			end
			default: begin
				state_nx = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= BK_IDLE;
			head_q       <= '0;
			fill_q       <= '0;
			wtot_q       <= '0;
			rtot_q       <= '0;
			ended_q      <= 1'b0;
			issue_left_q <= '0;
			emit_left_q  <= '0;
			rd_valid_q   <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q    <= state_nx;
			head_q     <= head_nx;
			fill_q     <= fill_nx;
			wtot_q     <= wtot_nx;
			rtot_q     <= rtot_nx;
			ended_q    <= ended_nx;
			rd_valid_q <= issue || (rd_valid_q && !consume);
			if (burst_start) begin
				issue_left_q <= BW'(n_fw);
				emit_left_q  <= BW'(n_fw);
			end else begin
				if (issue) begin
					issue_left_q <= issue_left_q - 1'b1;
				end
				if (consume) begin
					emit_left_q <= emit_left_q - 1'b1;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (burst_start) begin
			rd_ptr_q     <= head_q;
			burst_done_q <= (q_item.op == OP_READ) ? CNT_W'(n_fw) : '0;
		end else if (issue) begin
			rd_ptr_q <= (rd_ptr_q == PW'(CAPACITY - 1)) ? '0 : rd_ptr_q + 1'b1;
		end
		if (out_load) begin
			out_byte_q      <= ld_byte;
			byte_valid_q    <= ld_bv;
			last_q          <= ld_last;
			done_q          <= ld_done;
			fill_level_q    <= CNT_W'(fill_nx);
			space_left_q    <= CNT_W'(FW'(CAPACITY) - fill_nx);
			total_written_q <= wtot_nx;
			total_read_q    <= rtot_nx;
			ended_out_q     <= ended_nx;
			at_eof_q        <= ended_nx && (fill_nx == '0);
		end
	end

	// ring store
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[tail] <= q_item.data_byte;
		end
		if (issue) begin
			rd_data_q <= mem[rd_ptr_q];
		end
	end

	assign out_valid     = out_valid_q;
	assign out_byte      = out_byte_q;
	assign byte_valid    = byte_valid_q;
	assign last          = last_q;
	assign done_count    = done_q;
	assign fill_level    = fill_level_q;
	assign space_left    = space_left_q;
	assign total_written = total_written_q;
	assign total_read    = total_read_q;
	assign ended         = ended_out_q;
	assign at_eof        = at_eof_q;

endmodule

// File: design/flow_controlled_byte_fifo.sv
// Bounded byte FIFO with peek, pop, read and end-of-input commands. A front end
// decodes each command into a two-entry queue; a back end owns the single-port
// ring store and the status counters and returns results through an output
// register. Write, pop, end-input and unknown commands need no burst, so they
// sustain one transfer per clock while the output is not stalled. A peek or read
// that delivers n bytes (n at most MAX_BURST) holds the back end while it starts
// the burst, does the registered store read of the first byte and then delivers
// each byte in turn, waiting whenever the output is stalled.
// A peek or read with nothing to deliver starts no burst. Store contents need
// no clearing after reset; only entries inside the fill level are ever read.
module flow_controlled_byte_fifo import fcbf_pkg::*; #(
	parameter int CAPACITY  = CAPACITY_DEF,
	parameter int MAX_BURST = MAX_BURST_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [CMD_W-1:0]  cmd,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic [CNT_W-1:0]  count,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [BYTE_W-1:0] out_byte,
	output logic              byte_valid,
	output logic              last,
	output logic [CNT_W-1:0]  done_count,
	output logic [CNT_W-1:0]  fill_level,
	output logic [CNT_W-1:0]  space_left,
	output logic [TOT_W-1:0]  total_written,
	output logic [TOT_W-1:0]  total_read,
	output logic              ended,
	output logic              at_eof
);

	logic       q_valid;
	fcbf_item_t q_item;
	logic       q_take;

	fcbf_front #(
		.MAX_BURST (MAX_BURST)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.data_byte (data_byte),
		.count     (count),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_take    (q_take)
	);

	fcbf_back #(
		.CAPACITY  (CAPACITY),
		.MAX_BURST (MAX_BURST)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_take        (q_take),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_byte      (out_byte),
		.byte_valid    (byte_valid),
		.last          (last),
		.done_count    (done_count),
		.fill_level    (fill_level),
		.space_left    (space_left),
		.total_written (total_written),
		.total_read    (total_read),
		.ended         (ended),
		.at_eof        (at_eof)
	);

	// fill and free space always add up to the capacity
	a_fill_space: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((fill_level + space_left) == CNT_W'(CAPACITY)))
		else $error("fill level and space left disagree with capacity");

	a_eof_ended: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && at_eof) |-> (ended && fill_level == '0))
		else $error("eof without end of input or with data held");

	// a status-only result always closes its command
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !byte_valid) |-> (last && out_byte == '0))
		else $error("status result not marked last or carries a byte");

	// total read only moves by the bytes a transfer reports removed
	a_read_total: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall) ##1 (out_valid && !byte_valid)
		|-> ((total_read - $past(total_read)) == TOT_W'(done_count)
			|| total_read == $past(total_read)))
		else $error("read total moved without a matching removal");

endmodule

// File: dv/tb_flow_controlled_byte_fifo.sv
// testbench for flow_controlled_byte_fifo: directed table and random commands against a fifo model
module tb_flow_controlled_byte_fifo import fcbf_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD     = 12;
	localparam int RESET_CYCLES   = 12;
	localparam int CAPACITY       = CAPACITY_DEF;
	localparam int MAX_BURST      = MAX_BURST_DEF;
	localparam int RANDOM_ITEMS   = 458;
	localparam int DRAIN_CYCLES   = 4 * MAX_BURST;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int REPORT_LIMIT   = 10;
	localparam int DIR_ROWS       = 22;

	localparam logic [CMD_W-1:0] CMD_RSVD_FIRST = 3'd5;
	localparam logic [CMD_W-1:0] CMD_RSVD_LAST  = 3'd7;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              byte_valid;
		logic              last;
		logic [CNT_W-1:0]  done_count;
		logic [CNT_W-1:0]  fill_level;
		logic [CNT_W-1:0]  space_left;
		logic [TOT_W-1:0]  total_written;
		logic [TOT_W-1:0]  total_read;
		logic              ended;
		logic              at_eof;
	} fifo_status_t;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [BYTE_W-1:0] data_byte;
		logic [CNT_W-1:0]  count;
		logic              typed;
		fifo_status_t      status;
	} dir_row_t;

	localparam fifo_status_t UNTYPED    = '0;
	localparam fifo_status_t EMPTY_IDLE =
		'{8'h00, 1'b0, 1'b1, 11'd0, 11'd0, 11'd1024, 32'd0, 32'd0, 1'b0, 1'b0};

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [CMD_W-1:0]  cmd;
	logic [BYTE_W-1:0] data_byte;
	logic [CNT_W-1:0]  count;
	logic              out_valid;
	logic              out_stall;
	logic [BYTE_W-1:0] out_byte;
	logic              byte_valid;
	logic              last;
	logic [CNT_W-1:0]  done_count;
	logic [CNT_W-1:0]  fill_level;
	logic [CNT_W-1:0]  space_left;
	logic [TOT_W-1:0]  total_written;
	logic [TOT_W-1:0]  total_read;
	logic              ended;
	logic              at_eof;

	logic [BYTE_W-1:0] mirror_ring [CAPACITY];
	int                mirror_head;
	int                mirror_fill;
	logic [TOT_W-1:0]  mirror_written;
	logic [TOT_W-1:0]  mirror_read;
	logic              mirror_ended;

	fifo_status_t expected_status [$];
	int           mismatch_count;
	int           accepted_items;
	int           idle_cycles;
	int           stall_hold;
	int           stall_quiet;
	int           stall_pick;

	dir_row_t dir_rows [DIR_ROWS] = '{
		'{CMD_PEEK,       8'h00, 11'd0,    1'b1, EMPTY_IDLE},
		'{CMD_READ,       8'h00, 11'd1024, 1'b1, EMPTY_IDLE},
		'{CMD_POP,        8'h00, 11'd1024, 1'b1, EMPTY_IDLE},
		'{CMD_RSVD_LAST,  8'hff, 11'd1024, 1'b1, EMPTY_IDLE},
		'{CMD_WRITE,      8'h00, 11'd0,    1'b1,
			'{8'h00, 1'b0, 1'b1, 11'd1, 11'd1, 11'd1023, 32'd1, 32'd0, 1'b0, 1'b0}},
		'{CMD_WRITE,      8'hff, 11'd2047, 1'b1,
			'{8'h00, 1'b0, 1'b1, 11'd1, 11'd2, 11'd1022, 32'd2, 32'd0, 1'b0, 1'b0}},
		'{CMD_WRITE,      8'h5a, 11'd0,    1'b1,
			'{8'h00, 1'b0, 1'b1, 11'd1, 11'd3, 11'd1021, 32'd3, 32'd0, 1'b0, 1'b0}},
		'{CMD_PEEK,       8'h00, 11'd1,    1'b0, UNTYPED},
		'{CMD_PEEK,       8'h00, 11'd1024, 1'b0, UNTYPED},
		'{CMD_READ,       8'h00, 11'd1,    1'b0, UNTYPED},
		'{CMD_WRITE,      8'ha5, 11'd0,    1'b0, UNTYPED},
		'{CMD_WRITE,      8'h3c, 11'd0,    1'b0, UNTYPED},
		'{CMD_PEEK,       8'h00, 11'd1023, 1'b0, UNTYPED},
		'{CMD_READ,       8'h00, 11'd2,    1'b0, UNTYPED},
		'{CMD_RSVD_FIRST, 8'h00, 11'd0,    1'b0, UNTYPED},
		'{CMD_POP,        8'h00, 11'd1,    1'b0, UNTYPED},
		'{CMD_PEEK,       8'h00, 11'd1,    1'b0, UNTYPED},
		'{CMD_POP,        8'h00, 11'd1024, 1'b1,
			'{8'h00, 1'b0, 1'b1, 11'd1, 11'd0, 11'd1024, 32'd5, 32'd5, 1'b0, 1'b0}},
		'{CMD_END,        8'h00, 11'd0,    1'b1,
			'{8'h00, 1'b0, 1'b1, 11'd0, 11'd0, 11'd1024, 32'd5, 32'd5, 1'b1, 1'b1}},
		'{CMD_WRITE,      8'h81, 11'd0,    1'b1,
			'{8'h00, 1'b0, 1'b1, 11'd1, 11'd1, 11'd1023, 32'd6, 32'd5, 1'b1, 1'b0}},
		'{CMD_READ,       8'h00, 11'd64,   1'b0, UNTYPED},
		'{CMD_END,        8'h00, 11'd0,    1'b0, UNTYPED}
	};

	flow_controlled_byte_fifo i_dut (.*);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic fifo_status_t status_of(logic [BYTE_W-1:0] b, logic bv, logic lst,
			int done);
		return '{b, bv, lst, CNT_W'(done), CNT_W'(mirror_fill), CNT_W'(CAPACITY - mirror_fill),
			mirror_written, mirror_read, mirror_ended, mirror_ended && mirror_fill == 0};
	endfunction

	task automatic expect_result(input fifo_status_t s);
		expected_status = {expected_status, s};
	endtask

	task automatic retire_head(input int n);
		mirror_head = (mirror_head + n) % CAPACITY;
		mirror_fill -= n;
		mirror_read += TOT_W'(n);
	endtask

	task automatic predict_fifo_step(input logic [CMD_W-1:0] op,
			input logic [BYTE_W-1:0] value, input logic [CNT_W-1:0] want_n);
		int                take;
		int                done;
		logic [BYTE_W-1:0] burst [MAX_BURST];
		take = int'(want_n);
		done = 0;
		case (op) inside
		CMD_WRITE: begin
			if (mirror_fill < CAPACITY) begin
				mirror_ring[(mirror_head + mirror_fill) % CAPACITY] = value;
				mirror_fill++;
				mirror_written++;
				done = 1;
			end
		end
		CMD_PEEK, CMD_READ: begin
			if (take > MAX_BURST)
				take = MAX_BURST;
			if (take > mirror_fill)
				take = mirror_fill;
			for (int i = 0; i < take; i++)
				burst[i] = mirror_ring[(mirror_head + i) % CAPACITY];
			if (op == CMD_READ) begin
				retire_head(take);
				done = take;
			end
			if (take == 0)
				expect_result(status_of(8'h00, 1'b0, 1'b1, done));
			for (int i = 0; i < take; i++)
				expect_result(status_of(burst[i], 1'b1, i == take - 1, done));
			return;
		end
		CMD_POP: begin
			if (take > mirror_fill)
				take = mirror_fill;
			retire_head(take);
			done = take;
		end
		CMD_END: begin
			mirror_ended = 1'b1;
		end
		default: begin
		end
		endcase
		expect_result(status_of(8'h00, 1'b0, 1'b1, done));
	endtask

	function automatic string describe(fifo_status_t s);
		return $sformatf({"byte=%h bv=%b last=%b done=%0d fill=%0d space=%0d ",
			"wr=%0d rd=%0d end=%b eof=%b"},
			s.out_byte, s.byte_valid, s.last, s.done_count, s.fill_level, s.space_left,
			s.total_written, s.total_read, s.ended, s.at_eof);
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(6, 40);
	endfunction

	function automatic logic [CNT_W-1:0] pick_count();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return '0;
		if (r < 50)
			return CNT_W'($urandom_range(1, 8));
		if (r < 80)
			return CNT_W'($urandom_range(9, 80));
		if (r < 95)
			return CNT_W'($urandom_range(81, 1023));
		return CNT_W'(1024);
	endfunction

	function automatic logic [CMD_W-1:0] pick_cmd(int kind);
		int r;
		int w_write;
		int w_peek;
		int w_read;
		int w_pop;
		int w_end;
		r = $urandom_range(0, 99);
		case (kind)
		0: begin
			w_write = 75; w_peek = 85; w_read = 93; w_pop = 96; w_end = 98;
		end
		1: begin
			w_write = 30; w_peek = 50; w_read = 80; w_pop = 92; w_end = 95;
		end
		default: begin
			w_write = 50; w_peek = 65; w_read = 85; w_pop = 93; w_end = 96;
		end
		endcase
		if (r < w_write)
			return CMD_WRITE;
		if (r < w_peek)
			return CMD_PEEK;
		if (r < w_read)
			return CMD_READ;
		if (r < w_pop)
			return CMD_POP;
		if (r < w_end)
			return CMD_END;
		return CMD_W'($urandom_range(CMD_RSVD_FIRST, CMD_RSVD_LAST));
	endfunction

	task automatic send_item(input logic [CMD_W-1:0] c, input logic [BYTE_W-1:0] d,
			input logic [CNT_W-1:0] n, input int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		cmd       <= c;
		data_byte <= d;
		count     <= n;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// receiver stalls: mostly short, some long, with quiet stretches
	always @(posedge clk) begin
		if (stall_quiet > 0) begin
			stall_quiet--;
			out_stall <= 1'b0;
		end else if (stall_hold > 0) begin
			stall_hold--;
			out_stall <= 1'b1;
		end else begin
			stall_pick = $urandom_range(0, 99);
			if (stall_pick < 60) begin
				out_stall <= 1'b0;
			end else if (stall_pick < 90) begin
				out_stall <= 1'b1;
				stall_hold = $urandom_range(0, 2);
			end else if (stall_pick < 95) begin
				out_stall <= 1'b1;
				stall_hold = $urandom_range(5, 30);
			end else begin
				out_stall <= 1'b0;
				stall_quiet = $urandom_range(20, 100);
			end
		end
	end

	always @(posedge clk) begin
		fifo_status_t seen;
		fifo_status_t want;
		if (arst_n && in_valid && !in_stall) begin
			predict_fifo_step(cmd, data_byte, count);
			if (accepted_items < DIR_ROWS && dir_rows[accepted_items].typed)
				expected_status[expected_status.size() - 1] = dir_rows[accepted_items].status;
			accepted_items++;
		end
		if (arst_n && out_valid && !out_stall) begin
			seen = {out_byte, byte_valid, last, done_count, fill_level, space_left,
				total_written, total_read, ended, at_eof};
			if (expected_status.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("unexpected result transfer: %s", describe(seen));
			end else begin
				want = expected_status[0];
				expected_status.delete(0);
				if (seen !== want) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT) begin
						$display("mismatch expected: %s", describe(want));
						$display("mismatch actual:   %s", describe(seen));
					end
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("tb_flow_controlled_byte_fifo: FAIL");
			$finish;
		end
	end

	initial begin
		int phase_left;
		int phase_kind;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		cmd            = CMD_WRITE;
		data_byte      = '0;
		count          = '0;
		out_stall      = 1'b0;
		mirror_head    = 0;
		mirror_fill    = 0;
		mirror_written = '0;
		mirror_read    = '0;
		mirror_ended   = 1'b0;
		mismatch_count = 0;
		accepted_items = 0;
		idle_cycles    = 0;
		stall_hold     = 0;
		stall_quiet    = 0;
		phase_left     = 0;
		phase_kind     = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_item(dir_rows[i].cmd, dir_rows[i].data_byte, dir_rows[i].count, pick_gap());

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (phase_left == 0) begin
				phase_left = $urandom_range(16, 48);
				phase_kind = $urandom_range(0, 5);
			end
			phase_left--;
			send_item(pick_cmd(phase_kind % 3), BYTE_W'($urandom_range(0, 255)), pick_count(),
				phase_kind > 2 ? 0 : pick_gap());
		end
		in_valid <= 1'b0;

		while (expected_status.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && expected_status.size() == 0)
			$display("tb_flow_controlled_byte_fifo: PASS");
		else
			$display("tb_flow_controlled_byte_fifo: FAIL");
		$finish;
	end

endmodule
